>>> rtl/mkr_pkg.sv
// ----------------------------------------------------------------------------
// mkr_pkg
// Shared types and constants of the macro key report decoder.
// ----------------------------------------------------------------------------
package mkr_pkg;

  localparam int unsigned FRAME_BYTES = 512;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned KEY_COUNT   = 12;
  localparam int unsigned KEY_NUM_W   = 4;

  // Byte offsets of the two captured mask bytes
  localparam logic [POS_W-1:0] MASK1_OFF  = POS_W'(21 * 16 + 4);
  localparam logic [POS_W-1:0] MASK2_OFF  = POS_W'(23 * 16 + 12);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);

  // Pattern bytes
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_SYNC  = 8'h02;
  localparam logic [7:0] BYTE_FILL  = 8'hff;

  // Event kinds
  typedef enum logic [1:0] {
    EV_DOWN  = 2'd0,
    EV_UP    = 2'd1,
    EV_PRESS = 2'd2
  } ev_kind_t;

  // One good frame's worth of work for the emitter
  typedef struct packed {
    logic [KEY_COUNT-1:0] emit;   // keys that produce an event
    logic [KEY_COUNT-1:0] keys;   // new key state, bit k-1 = key k
    logic                 single; // single-press mode at frame end
  } ev_rec_t;

  // Expected byte at a given frame offset
  function automatic logic [7:0] expected_byte(input logic [POS_W-1:0] pos);
    logic [3:0] col;
    logic [7:0] res;
    col = pos[3:0];
    res = BYTE_ZERO;
    if (col == 4'd0 || col == 4'd8) begin
      res = BYTE_SYNC;
    end else if (col == 4'd3 || col == 4'd11) begin
      res = BYTE_FILL;
    end else if (col == 4'd4 && pos[POS_W-1:4] == '0) begin
      res = BYTE_START;
    end
    return res;
  endfunction

endpackage

>>> rtl/mkr_front.sv
// ----------------------------------------------------------------------------
// mkr_front
// Frame parser: tracks the frame offset, checks each byte against the fixed
// pattern, captures the mask bytes, posts one record per good frame with events.
// ----------------------------------------------------------------------------
module mkr_front
  import mkr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] byte_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  output logic       push,
  output ev_rec_t    push_rec
);

  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 bad_r, bad_nxt;
  logic [7:0]           mask1_r, mask1_nxt;
  logic [7:0]           mask2_r, mask2_nxt;
  logic [KEY_COUNT-1:0] key_state_r, key_state_nxt;
  logic                 single_r;

  logic                 in_frame;
  logic                 mismatch;
  logic                 frame_end;
  logic [KEY_COUNT-1:0] now_keys;
  logic [KEY_COUNT-1:0] diff;

  // Byte classification
  assign in_frame  = byte_vld && !(pos_r == '0 && byte_data == BYTE_ZERO);
  assign mismatch  = (pos_r != MASK1_OFF) && (pos_r != MASK2_OFF) &&
                     (byte_data != expected_byte(pos_r));
  assign frame_end = in_frame && (pos_r == LAST_POS);

  // Key state of this frame; mask2 is already captured by the last byte
  assign now_keys = {mask2_r[4:0], mask1_r[7:1]};
  assign diff     = now_keys ^ key_state_r;

  // Next state
  always_comb begin
    pos_nxt       = pos_r;
    bad_nxt       = bad_r;
    mask1_nxt     = mask1_r;
    mask2_nxt     = mask2_r;
    key_state_nxt = key_state_r;
    if (in_frame) begin
      pos_nxt = pos_r + POS_W'(1);
      bad_nxt = ((pos_r == '0) ? 1'b0 : bad_r) | mismatch;
      if (pos_r == MASK1_OFF) mask1_nxt = byte_data;
      if (pos_r == MASK2_OFF) mask2_nxt = byte_data;
      if (frame_end) begin
        pos_nxt = '0;
        if (!bad_nxt) key_state_nxt = now_keys;
      end
    end
  end

  // Record for the emitter
  always_comb begin
    push_rec.keys   = now_keys;
    push_rec.single = single_r;
    push_rec.emit   = single_r ? (diff & now_keys) : diff;
    push            = frame_end && !bad_nxt && (push_rec.emit != '0);
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      bad_r       <= 1'b0;
      mask1_r     <= '0;
      mask2_r     <= '0;
      key_state_r <= '0;
      single_r    <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      bad_r       <= bad_nxt;
      mask1_r     <= mask1_nxt;
      mask2_r     <= mask2_nxt;
      key_state_r <= key_state_nxt;
      if (cfg_wr_en) single_r <= cfg_wr_data;
    end
  end

endmodule

>>> rtl/mkr_queue.sv
// ----------------------------------------------------------------------------
// mkr_queue
// Small register queue of frame records between parser and emitter.
// ----------------------------------------------------------------------------
module mkr_queue
  import mkr_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ev_rec_t push_rec,
  input  logic    pop,
  output ev_rec_t head_rec,
  output logic    empty,
  output logic    full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ev_rec_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

>>> rtl/mkr_back.sv
// ----------------------------------------------------------------------------
// mkr_back
// Event emitter: walks the changed keys of one record in key order and
// drives one event per cycle into the output register unless out_rdy stalls it.
// ----------------------------------------------------------------------------
module mkr_back
  import mkr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ev_rec_t              q_head,
  output logic                 q_pop,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output logic [KEY_NUM_W-1:0] out_key,
  output ev_kind_t             out_kind,
  output logic                 out_last
);

  logic                 busy_r;
  logic [KEY_COUNT-1:0] rem_r;
  logic [KEY_COUNT-1:0] keys_r;
  logic                 single_r;
  logic                 vld_r;
  logic [KEY_NUM_W-1:0] key_r;
  ev_kind_t             kind_r;
  logic                 last_r;

  logic                 adv;
  logic [KEY_NUM_W-1:0] idx;
  logic [KEY_COUNT-1:0] rem_after;
  logic                 is_last;
  ev_kind_t             kind_sel;

  assign q_pop = !busy_r && !q_empty;
  assign adv   = busy_r && (!vld_r || out_rdy);

  // Lowest pending key
  always_comb begin
    idx = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (rem_r[k]) idx = KEY_NUM_W'(k);
    end
  end

  assign rem_after = rem_r & (rem_r - KEY_COUNT'(1));
  assign is_last   = (rem_after == '0);

  always_comb begin
    if (single_r) begin
      kind_sel = EV_PRESS;
    end else if (keys_r[idx]) begin
      kind_sel = EV_DOWN;
    end else begin
      kind_sel = EV_UP;
    end
  end

  // Control and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (adv && is_last) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        vld_r <= 1'b1;
      end else if (out_rdy) begin
        vld_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_r    <= q_head.emit;
      keys_r   <= q_head.keys;
      single_r <= q_head.single;
    end else if (adv) begin
      rem_r <= rem_after;
    end
    if (adv) begin
      key_r  <= idx + KEY_NUM_W'(1);
      kind_r <= kind_sel;
      last_r <= is_last;
    end
  end

  assign out_vld  = vld_r;
  assign out_key  = key_r;
  assign out_kind = kind_r;
  assign out_last = last_r;

endmodule

>>> rtl/macro_key_report_decoder.sv
// ----------------------------------------------------------------------------
// macro_key_report_decoder
// Decodes 512-byte key reports into key down, key up or single press items.
// ----------------------------------------------------------------------------
// Input channel in_*: one raw report byte per item in in_tdata. While idle a
// zero byte is dropped and a nonzero byte opens a frame. in_tready is high
// whenever the record queue has room, so bytes go in at one per cycle.
// Output out_*: one item per changed key (per new press in single-press mode),
// out_tdata key number, out_tuser event kind, out_tlast last item of a frame.
// cfg_wr_en/cfg_wr_data set single-press mode; write only while idle.
// After the frame's last byte is taken, the first item of a good frame
// passes the record queue, the emitter load and the output register.
// Throughput: one item per cycle while out_tready is high, plus an emitter
// load per frame; a 512-byte frame yields at most 12 items, so it keeps up.
// A stalled receiver holds the output register; frames keep arriving until
// the queue of QUEUE_DEPTH records fills, then in_tready drops.
// Reset (synchronous, rst_n low): idle, all keys up, queue empty,
// single-press mode off.
// ----------------------------------------------------------------------------
module macro_key_report_decoder
  import mkr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input bytes
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  // Key events
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] key_number, [7:4] zero
  output logic [1:0] out_tuser,  // [1:0] event_kind
  output logic       out_tlast,  // last_event
  // Configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data // single_press_mode
);

  logic                 push;
  ev_rec_t              push_rec;
  logic                 q_pop;
  ev_rec_t              q_head;
  logic                 q_empty;
  logic                 q_full;
  logic [KEY_NUM_W-1:0] out_key;
  ev_kind_t             out_kind;

  assign in_tready = !q_full;

  // Frame parser
  mkr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_vld    (in_tvalid && in_tready),
    .byte_data   (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_rec    (push_rec)
  );

  // Record queue
  mkr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Event emitter
  mkr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_key  (out_key),
    .out_kind (out_kind),
    .out_last (out_tlast)
  );

  assign out_tdata = {4'b0000, out_key};
  assign out_tuser = out_kind;

  // Assertions
  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("record posted while queue full");

  a_key_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_key != '0 && out_key <= KEY_NUM_W'(KEY_COUNT)))
    else $error("key number out of range");

  a_kind_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_kind == EV_DOWN || out_kind == EV_UP || out_kind == EV_PRESS))
    else $error("bad event kind");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("emitter loaded from empty queue");

endmodule
